// File: sv/crw_pkg.sv
// Shared types, register codes and constants for the commit-rate watchdog.
package crw_pkg;

   localparam int MAX_LANES_DEF     = 8;
   localparam int COUNT_BITS_DEF    = 48;
   localparam int WARMUP_CYCLES_DEF = 20000;

   localparam int MASK_W     = 8;
   localparam int LIMIT_W    = 48;
   localparam int WLEN_W     = 24;
   localparam int WINST_W    = 28;
   localparam int FLOOR_W    = 4;
   localparam int LANES_W    = 4;
   localparam int STATUS_W   = 3;
   localparam int TOTAL_W    = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 104;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
   localparam logic [WLEN_W-1:0]  WLEN_RESET  = 24'd10000;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = '0;
   localparam logic [LANES_W-1:0] LANES_RESET = 4'd8;

   // Rate thresholds as exact cross-multiplication factors
   localparam int STALL_SCALE = 100000;  // rate <= 1e-5
   localparam int NEAR_SCALE  = 5000;    // |rate - 0.5| < 1e-4

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_INST_LIMIT  = 3'd1,
      ST_CYCLE_LIMIT = 3'd2,
      ST_STALLED     = 3'd3,
      ST_LOW_RATE    = 3'd4,
      ST_PANIC       = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INST_LIMIT    = 3'd0,
      REG_CYCLE_LIMIT   = 3'd1,
      REG_WINDOW_LENGTH = 3'd2,
      REG_RATE_FLOOR    = 3'd3,
      REG_IGNORE_PANIC  = 3'd4,
      REG_LANES_IN_USE  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] inst_limit;
      logic [LIMIT_W-1:0] cycle_limit;
      logic [WLEN_W-1:0]  window_length;
      logic [FLOOR_W-1:0] rate_floor;
      logic               ignore_panic;
      logic [LANES_W-1:0] lanes_in_use;
   } cfg_type;

endpackage

// File: sv/commit_rate_watchdog_core.sv
// Commit-rate watchdog: commit lanes feed the counter and window-check stage.
// A request accepted into the lane register moves on to the response register when that is free or drains.
// One commit mask per cycle while the response register is free or drains; the counter stage feeds its next value back.
// The response register holds a stalled response while the next request still enters.
// Reset (synchronous, active high) clears counters, window history and valids,
// and loads the configuration defaults; csr writes are always taken.
module commit_rate_watchdog_core #(
   parameter int MAX_LANES     = crw_pkg::MAX_LANES_DEF,
   parameter int COUNT_BITS    = crw_pkg::COUNT_BITS_DEF,
   parameter int WARMUP_CYCLES = crw_pkg::WARMUP_CYCLES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [crw_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] commit_mask
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] status, [50:3] cycle_total, [98:51] inst_total, [103:99] zero
   output logic [crw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int NUM_LANES = (MAX_LANES < crw_pkg::MASK_W) ? MAX_LANES : crw_pkg::MASK_W;
   localparam int CNT_W     = $clog2(NUM_LANES + 1);

   crw_pkg::cfg_type              cfg_ff, cfg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          lane_valid, take, accept, step;
   logic [CNT_W-1:0]              lane_count;
   logic [crw_pkg::STATUS_W-1:0]  status;
   logic [crw_pkg::TOTAL_W-1:0]   cycle_total, inst_total;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (crw_pkg::csr_reg_type'(csr_index))
            crw_pkg::REG_INST_LIMIT:    cfg_in.inst_limit    = csr_wdata[crw_pkg::LIMIT_W-1:0];
            crw_pkg::REG_CYCLE_LIMIT:   cfg_in.cycle_limit   = csr_wdata[crw_pkg::LIMIT_W-1:0];
            crw_pkg::REG_WINDOW_LENGTH: cfg_in.window_length = csr_wdata[crw_pkg::WLEN_W-1:0];
            crw_pkg::REG_RATE_FLOOR:    cfg_in.rate_floor    = csr_wdata[crw_pkg::FLOOR_W-1:0];
            crw_pkg::REG_IGNORE_PANIC:  cfg_in.ignore_panic  = csr_wdata[0];
            crw_pkg::REG_LANES_IN_USE:  cfg_in.lanes_in_use  = csr_wdata[crw_pkg::LANES_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // Advance the lane stage when the response register is free or drains
   assign take       = !rsp_valid_ff || rsp_tready;
   assign step       = lane_valid && take;
   assign req_tready = !lane_valid || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inst_limit    <= crw_pkg::LIMIT_RESET;
         cfg_ff.cycle_limit   <= crw_pkg::LIMIT_RESET;
         cfg_ff.window_length <= crw_pkg::WLEN_RESET;
         cfg_ff.rate_floor    <= crw_pkg::FLOOR_RESET;
         cfg_ff.ignore_panic  <= 1'b0;
         cfg_ff.lanes_in_use  <= crw_pkg::LANES_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   crw_lanes #(
      .MAX_LANES (MAX_LANES)
   ) u_lanes (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .drain        (step),
      .commit_mask  (req_tdata[crw_pkg::MASK_W-1:0]),
      .lanes_in_use (cfg_ff.lanes_in_use),
      .valid        (lane_valid),
      .count        (lane_count)
   );

   crw_monitor #(
      .COUNT_BITS    (COUNT_BITS),
      .WARMUP_CYCLES (WARMUP_CYCLES),
      .CNT_W         (CNT_W)
   ) u_monitor (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .lane_count  (lane_count),
      .cfg         (cfg_ff),
      .status      (status),
      .cycle_total (cycle_total),
      .inst_total  (inst_total)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, inst_total, cycle_total, status};

endmodule

// File: sv/crw_lanes.sv
// Per-slot commit lanes and the merging adder that yields a registered commit count.
module crw_lanes #(
   parameter int MAX_LANES = crw_pkg::MAX_LANES_DEF,
   localparam int NUM_LANES = (MAX_LANES < crw_pkg::MASK_W) ? MAX_LANES : crw_pkg::MASK_W,
   localparam int CNT_W = $clog2(NUM_LANES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        drain,
   input  logic [crw_pkg::MASK_W-1:0]  commit_mask,
   input  logic [crw_pkg::LANES_W-1:0] lanes_in_use,
   output logic                        valid,
   output logic [CNT_W-1:0]            count
);

   logic [NUM_LANES-1:0] hit;
   logic [CNT_W-1:0]     sum;
   logic                 valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // A lane counts only when its slot lies below the lanes in use
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      assign hit[k] = commit_mask[k] &
                      (lanes_in_use > crw_pkg::LANES_W'(k));
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         sum = sum + CNT_W'(hit[k]);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (load) begin
         valid_in = 1'b1;
         count_in = sum;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign count = count_ff;

endmodule

// File: sv/crw_monitor.sv
// Cycle and instruction counters, window rate checks and status register.
module crw_monitor #(
   parameter int COUNT_BITS    = crw_pkg::COUNT_BITS_DEF,
   parameter int WARMUP_CYCLES = crw_pkg::WARMUP_CYCLES_DEF,
   parameter int CNT_W         = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [CNT_W-1:0]             lane_count,
   input  crw_pkg::cfg_type             cfg,
   output logic [crw_pkg::STATUS_W-1:0] status,
   output logic [crw_pkg::TOTAL_W-1:0]  cycle_total,
   output logic [crw_pkg::TOTAL_W-1:0]  inst_total
);

   localparam int CMP_W   = (COUNT_BITS > crw_pkg::LIMIT_W) ? COUNT_BITS : crw_pkg::LIMIT_W;
   localparam int WC_W    = crw_pkg::WLEN_W;
   localparam int WI_W    = crw_pkg::WINST_W;
   localparam int DIFF_W  = WI_W + 1;
   localparam int STALL_W = WI_W + 17;
   localparam int NEAR_W  = DIFF_W + 13;

   logic [COUNT_BITS-1:0]  cycles_ff, cycles_in, insts_ff, insts_in;
   logic [WC_W-1:0]        wcyc_ff, wcyc_in;
   logic [WI_W-1:0]        winst_ff, winst_in;
   logic                   last_near_ff, last_near_in, prev_near_ff, prev_near_in;
   crw_pkg::status_type    status_ff, status_in;

   logic [COUNT_BITS:0]    cyc_sum, ins_sum;
   logic [WC_W:0]          wc_sum;
   logic [WI_W:0]          wi_sum;
   logic [COUNT_BITS-1:0]  cyc_next, ins_next;
   logic [WC_W-1:0]        wc_next;
   logic [WI_W-1:0]        wi_next;
   logic [DIFF_W-1:0]      twice, wc_wide, diff;
   logic [STALL_W-1:0]     stall_prod;
   logic [NEAR_W-1:0]      near_prod;
   logic [WI_W-1:0]        floor_prod;
   logic                   inst_hit, cycle_hit, window_due, stalled, near, low, panic;
   logic                   roll;

   // Saturating counter steps
   always_comb begin
      cyc_sum  = {1'b0, cycles_ff} + (COUNT_BITS + 1)'(1);
      ins_sum  = {1'b0, insts_ff} + (COUNT_BITS + 1)'(lane_count);
      wc_sum   = {1'b0, wcyc_ff} + (WC_W + 1)'(1);
      wi_sum   = {1'b0, winst_ff} + (WI_W + 1)'(lane_count);
      cyc_next = cyc_sum[COUNT_BITS] ? '1 : cyc_sum[COUNT_BITS-1:0];
      ins_next = ins_sum[COUNT_BITS] ? '1 : ins_sum[COUNT_BITS-1:0];
      wc_next  = wc_sum[WC_W] ? '1 : wc_sum[WC_W-1:0];
      wi_next  = wi_sum[WI_W] ? '1 : wi_sum[WI_W-1:0];
   end

   // Window rate tests by cross-multiplication
   always_comb begin
      inst_hit   = CMP_W'(ins_next) >= CMP_W'(cfg.inst_limit);
      cycle_hit  = CMP_W'(cyc_next) >= CMP_W'(cfg.cycle_limit);
      window_due = (wc_next >= cfg.window_length) &&
                   (cyc_next > COUNT_BITS'(WARMUP_CYCLES));
      twice      = {wi_next, 1'b0};
      wc_wide    = DIFF_W'(wc_next);
      diff       = (twice > wc_wide) ? (twice - wc_wide) : (wc_wide - twice);
      stall_prod = STALL_W'(wi_next) * STALL_W'(crw_pkg::STALL_SCALE);
      near_prod  = NEAR_W'(diff) * NEAR_W'(crw_pkg::NEAR_SCALE);
      floor_prod = WI_W'(cfg.rate_floor) * WI_W'(wc_next);
      stalled    = stall_prod <= STALL_W'(wc_next);
      near       = near_prod < NEAR_W'(wc_next);
      low        = wi_next <= floor_prod;
      panic      = !cfg.ignore_panic && near && last_near_ff && prev_near_ff;
   end

   always_comb begin
      roll      = 1'b0;
      status_in = crw_pkg::ST_OK;
      priority if (inst_hit) begin
         status_in = crw_pkg::ST_INST_LIMIT;
      end else if (cycle_hit) begin
         status_in = crw_pkg::ST_CYCLE_LIMIT;
      end else if (window_due && stalled) begin
         status_in = crw_pkg::ST_STALLED;
      end else if (window_due && panic) begin
         status_in = crw_pkg::ST_PANIC;
      end else if (window_due) begin
         roll      = 1'b1;
         status_in = low ? crw_pkg::ST_LOW_RATE : crw_pkg::ST_OK;
      end else begin
         status_in = crw_pkg::ST_OK;
      end

      cycles_in    = cycles_ff;
      insts_in     = insts_ff;
      wcyc_in      = wcyc_ff;
      winst_in     = winst_ff;
      last_near_in = last_near_ff;
      prev_near_in = prev_near_ff;
      if (step) begin
         cycles_in = cyc_next;
         insts_in  = ins_next;
         // Clear the window and shift history only on a closed window that raised no limit, stall or panic
         if (roll) begin
            wcyc_in      = '0;
            winst_in     = '0;
            prev_near_in = last_near_ff;
            last_near_in = near;
         end else begin
            wcyc_in  = wc_next;
            winst_in = wi_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycles_ff    <= '0;
         insts_ff     <= '0;
         wcyc_ff      <= '0;
         winst_ff     <= '0;
         last_near_ff <= 1'b0;
         prev_near_ff <= 1'b0;
      end else begin
         cycles_ff    <= cycles_in;
         insts_ff     <= insts_in;
         wcyc_ff      <= wcyc_in;
         winst_ff     <= winst_in;
         last_near_ff <= last_near_in;
         prev_near_ff <= prev_near_in;
      end
      if (step) begin
         status_ff <= status_in;
      end
   end

   assign status      = status_ff;
   assign cycle_total = crw_pkg::TOTAL_W'(cycles_ff);
   assign inst_total  = crw_pkg::TOTAL_W'(insts_ff);

endmodule

// File: sv/crw_checker.sv
// Port-level assertions for the commit-rate watchdog and their bind.
module crw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [crw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Nothing left over after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // An empty response register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty response register");

   // Totals never go backward between back-to-back responses
   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready ##1 rsp_tvalid |->
         (rsp_tdata[50:3] >= $past(rsp_tdata[50:3])) &&
         (rsp_tdata[98:51] >= $past(rsp_tdata[98:51])))
      else $error("total count decreased");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind commit_rate_watchdog_core crw_checker u_crw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
